// ===== hw/rtl/ile_pkg.sv =====
`default_nettype none
package ile_pkg;

  localparam logic [2:0] REQ_PUSH    = 3'd0;
  localparam logic [2:0] REQ_POP     = 3'd1;
  localparam logic [2:0] REQ_GET     = 3'd2;
  localparam logic [2:0] REQ_UNSHIFT = 3'd3;
  localparam logic [2:0] REQ_INSERT  = 3'd4;
  localparam logic [2:0] REQ_SHIFT   = 3'd5;
  localparam logic [2:0] REQ_DELETE  = 3'd6;
  localparam logic [2:0] REQ_FIND    = 3'd7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef enum logic [2:0] {
    RD_DOWN,
    RD_UP,
    RD_CUR,
    RD_POS,
    RD_LAST
  } rd_sel_t;

  typedef struct packed {
    logic       load;
    logic       rd_en;
    rd_sel_t    rd_sel;
    logic       wr_copy;
    logic       wr_item;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       cur_up;
    logic       cur_down;
    logic       set_status;
    logic [1:0] status;
    logic       set_data;
    logic       set_found;
    logic       publish;
  } cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       full;
    logic       empty;
    logic       pos_gt;
    logic       pos_ge;
    logic       open_more;
    logic       close_more;
    logic       scan_more;
    logic       match;
    logic       out_free;
  } stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ile_ctrl.sv =====
`default_nettype none
module ile_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire ile_pkg::stat_t st,
  output ile_pkg::cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_OPEN,
    S_OPEN_WR,
    S_CLOSE,
    S_CLOSE_WR,
    S_FIND,
    S_FIND_CMP,
    S_READ_WAIT,
    S_DONE
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = ile_pkg::RD_CUR;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_DONE;
        case (st.req_type)
          ile_pkg::REQ_PUSH, ile_pkg::REQ_UNSHIFT, ile_pkg::REQ_INSERT: begin
            if (st.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ile_pkg::ST_FULL;
            end else if (st.pos_gt) begin
              cmd.set_status = 1'b1;
              cmd.status     = ile_pkg::ST_RANGE;
            end else begin
              state_next = S_OPEN;
            end
          end
          ile_pkg::REQ_POP: begin
            if (st.empty) begin
              cmd.set_status = 1'b1;
              cmd.status     = ile_pkg::ST_EMPTY;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = ile_pkg::RD_LAST;
              cmd.cnt_dec = 1'b1;
              state_next = S_READ_WAIT;
            end
          end
          ile_pkg::REQ_GET: begin
            if (st.empty) begin
              cmd.set_status = 1'b1;
              cmd.status     = ile_pkg::ST_EMPTY;
            end else if (st.pos_ge) begin
              cmd.set_status = 1'b1;
              cmd.status     = ile_pkg::ST_RANGE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = ile_pkg::RD_POS;
              state_next = S_READ_WAIT;
            end
          end
          ile_pkg::REQ_SHIFT, ile_pkg::REQ_DELETE: begin
            if (st.empty) begin
              cmd.set_status = 1'b1;
              cmd.status     = ile_pkg::ST_EMPTY;
            end else if (st.pos_ge) begin
              cmd.set_status = 1'b1;
              cmd.status     = ile_pkg::ST_RANGE;
            end else begin
              state_next = S_CLOSE;
            end
          end
          default: begin
            if (st.empty) begin
              cmd.set_status = 1'b1;
              cmd.status     = ile_pkg::ST_EMPTY;
            end else begin
              state_next = S_FIND;
            end
          end
        endcase
      end
      S_OPEN: begin
        if (st.open_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ile_pkg::RD_DOWN;
          state_next = S_OPEN_WR;
        end else begin
          cmd.wr_item = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_OPEN_WR: begin
        cmd.wr_copy  = 1'b1;
        cmd.cur_down = 1'b1;
        state_next   = S_OPEN;
      end
      S_CLOSE: begin
        if (st.close_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ile_pkg::RD_UP;
          state_next = S_CLOSE_WR;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_CLOSE_WR: begin
        cmd.wr_copy = 1'b1;
        cmd.cur_up  = 1'b1;
        state_next  = S_CLOSE;
      end
      S_FIND: begin
        if (st.scan_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ile_pkg::RD_CUR;
          state_next = S_FIND_CMP;
        end else begin
          state_next = S_DONE;
        end
      end
      S_FIND_CMP: begin
        if (st.match) begin
          cmd.set_found = 1'b1;
          state_next    = S_DONE;
        end else begin
          cmd.cur_up = 1'b1;
          state_next = S_FIND;
        end
      end
      S_READ_WAIT: begin
        cmd.set_data = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ile_dpath.sv =====
`default_nettype none
module ile_dpath #(
  parameter int CAPACITY = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire ile_pkg::cmd_t cmd,
  output ile_pkg::stat_t     st,
  input  wire logic [2:0]    req_type,
  input  wire logic [6:0]    position,
  input  wire logic [63:0]   item_value,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [1:0]         status,
  output logic [63:0]        read_data,
  output logic               found,
  output logic [5:0]         found_index,
  output logic [6:0]         list_len
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 7) ? CW : 7;

  logic [63:0]   mem [CAPACITY];
  logic [63:0]   rdata;
  logic [CW-1:0] count;
  logic [CW-1:0] cursor;
  logic [CW-1:0] rd_full;
  logic [PW-1:0] pos_r;
  logic [PW-1:0] pos_load;
  logic [2:0]    req_r;
  logic [63:0]   val_r;
  logic [1:0]    res_status;
  logic [63:0]   res_data;
  logic          res_found;
  logic [5:0]    res_idx;

  always_comb begin
    case (req_type)
      ile_pkg::REQ_PUSH:                     pos_load = PW'(count);
      ile_pkg::REQ_UNSHIFT, ile_pkg::REQ_SHIFT: pos_load = '0;
      default:                               pos_load = PW'(position);
    endcase
  end

  always_comb begin
    case (cmd.rd_sel)
      ile_pkg::RD_DOWN: rd_full = cursor - CW'(1);
      ile_pkg::RD_UP:   rd_full = cursor + CW'(1);
      ile_pkg::RD_POS:  rd_full = CW'(pos_r);
      ile_pkg::RD_LAST: rd_full = count - CW'(1);
      default:          rd_full = cursor;
    endcase
  end

  // List storage: one read and one write port, read data registered.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata <= mem[rd_full[AW-1:0]];
    end
    if (cmd.wr_copy) begin
      mem[cursor[AW-1:0]] <= rdata;
    end else if (cmd.wr_item) begin
      mem[pos_r[AW-1:0]] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= req_type;
      val_r <= item_value;
      pos_r <= pos_load;
      case (req_type)
        ile_pkg::REQ_PUSH, ile_pkg::REQ_UNSHIFT, ile_pkg::REQ_INSERT: cursor <= count;
        ile_pkg::REQ_SHIFT, ile_pkg::REQ_DELETE: cursor <= CW'(pos_load);
        default: cursor <= '0;
      endcase
      res_status <= ile_pkg::ST_OK;
      res_data   <= '0;
      res_found  <= 1'b0;
      res_idx    <= '0;
    end else begin
      if (cmd.cur_up) begin
        cursor <= cursor + CW'(1);
      end else if (cmd.cur_down) begin
        cursor <= cursor - CW'(1);
      end
      if (cmd.set_status) begin
        res_status <= cmd.status;
      end
      if (cmd.set_data) begin
        res_data <= rdata;
      end
      if (cmd.set_found) begin
        res_found <= 1'b1;
        res_idx   <= 6'(cursor);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        count <= count + CW'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CW'(1);
      end
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      status      <= res_status;
      read_data   <= res_data;
      found       <= res_found;
      found_index <= res_idx;
      list_len    <= 7'(count);
    end
  end

  always_comb begin
    st.req_type   = req_r;
    st.full       = (count >= CW'(CAPACITY));
    st.empty      = (count == '0);
    st.pos_gt     = (pos_r > PW'(count));
    st.pos_ge     = (pos_r >= PW'(count));
    st.open_more  = (PW'(cursor) > pos_r);
    st.close_more = (({1'b0, cursor} + (CW + 1)'(1)) < {1'b0, count});
    st.scan_more  = (cursor < count);
    st.match      = (rdata == val_r);
    st.out_free   = !out_valid || out_ready;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY)) else $error("list count above capacity");
  a_no_grow_full: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |-> !st.full) else $error("grow on full list");
  a_no_shrink_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_dec |-> !st.empty) else $error("shrink on empty list");
  a_copy_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_copy |-> $past(cmd.rd_en)) else $error("copy without preceding read");

endmodule
`default_nettype wire

// ===== hw/rtl/indexed_list_engine.sv =====
`default_nettype none
// Bounded ordered list of up to CAPACITY 64-bit values, one request per transaction.
// Requests arrive on the s_ channel; each produces exactly one result transaction on
// the m_ channel carrying status, read data, find result and the list length after
// the request.
// Push, pop and get move no entries. Insert and unshift move each entry at or above
// the position up by one, delete and shift move each entry above the position down
// by one, and find compares entries from index 0 up to the first match; every moved
// or compared entry goes through the single read port of the list memory and its
// registered read data.
// One request is worked on at a time; s_tready is high only when the engine is idle.
// A finished result sits in the output register until taken, and the next request is
// accepted and processed meanwhile; if the receiver stalls, that next result waits
// in the engine until the output register is free.
// Reset clears the list length and the output valid; memory contents are not cleared,
// since only entries below the length are ever read.
module indexed_list_engine #(
  parameter int CAPACITY = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // req_type[2:0], position[9:3], item_value[73:10], zero[79:74]
  input  wire logic [79:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // status[1:0], read_data[65:2], found[66], found_index[72:67], list_len[79:73]
  output logic [79:0]      m_tdata
);

  ile_pkg::cmd_t  cmd;
  ile_pkg::stat_t st;

  logic [1:0]  status;
  logic [63:0] read_data;
  logic        found;
  logic [5:0]  found_index;
  logic [6:0]  list_len;

  ile_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  ile_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .req_type    (s_tdata[2:0]),
    .position    (s_tdata[9:3]),
    .item_value  (s_tdata[73:10]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .status      (status),
    .read_data   (read_data),
    .found       (found),
    .found_index (found_index),
    .list_len    (list_len)
  );

  assign m_tdata = {list_len, found_index, found, read_data, status};

endmodule
`default_nettype wire

// ===== tb/sv/indexed_list_engine_test.sv =====
`timescale 1ns / 1ps
module indexed_list_engine_test;

  localparam int CAPACITY = 64;
  // Longest requests move or scan nearly every entry of a nearly full list.
  // The limit covers those, the receiver hold-off and the random gaps many times over.
  localparam int IDLE_LIMIT = 20000;

  // Packed from the top bit down, so status lands in the lowest bits as on m_tdata.
  typedef struct packed {
    logic [6:0]  list_len;
    logic [5:0]  found_index;
    logic        found;
    logic [63:0] read_data;
    logic [1:0]  status;
  } list_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [79:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [79:0] m_tdata;

  // The shadow copy of the list that the predictor keeps.
  logic [63:0]  shadow_list[$];
  list_result_t expected_results[$];
  int           error_count;
  int           idle_cycles;
  bit           sender_steady;
  bit           receiver_steady;
  int           receiver_holdoff;
  bit           done;

  indexed_list_engine #(.CAPACITY(CAPACITY)) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Works out the result of one request and updates the shadow list to match.
  function automatic list_result_t apply_list_request(logic [2:0] req, logic [6:0] pos,
                                                      logic [63:0] value);
    list_result_t r;
    int n;
    int at;
    n = shadow_list.size();
    r = '0;
    r.status = ile_pkg::ST_OK;
    case (req)
      ile_pkg::REQ_PUSH, ile_pkg::REQ_UNSHIFT, ile_pkg::REQ_INSERT: begin
        at = (req == ile_pkg::REQ_PUSH) ? n :
             (req == ile_pkg::REQ_UNSHIFT) ? 0 : int'(pos);
        // A full list is reported before the position is checked.
        if (n >= CAPACITY) begin
          r.status = ile_pkg::ST_FULL;
        end else if (at > n) begin
          r.status = ile_pkg::ST_RANGE;
        end else begin
          shadow_list.insert(at, value);
        end
      end
      ile_pkg::REQ_POP: begin
        if (n == 0) begin
          r.status = ile_pkg::ST_EMPTY;
        end else begin
          r.read_data = shadow_list.pop_back();
        end
      end
      ile_pkg::REQ_GET: begin
        if (n == 0) begin
          r.status = ile_pkg::ST_EMPTY;
        end else if (int'(pos) >= n) begin
          r.status = ile_pkg::ST_RANGE;
        end else begin
          r.read_data = shadow_list[pos];
        end
      end
      ile_pkg::REQ_SHIFT: begin
        // Shift drops the first entry but does not return it.
        if (n == 0) begin
          r.status = ile_pkg::ST_EMPTY;
        end else begin
          void'(shadow_list.pop_front());
        end
      end
      ile_pkg::REQ_DELETE: begin
        if (n == 0) begin
          r.status = ile_pkg::ST_EMPTY;
        end else if (int'(pos) >= n) begin
          r.status = ile_pkg::ST_RANGE;
        end else begin
          shadow_list.delete(pos);
        end
      end
      default: begin
        if (n == 0) begin
          r.status = ile_pkg::ST_EMPTY;
        end else begin
          for (int k = n - 1; k >= 0; k--) begin
            if (shadow_list[k] == value) begin
              r.found = 1'b1;
              r.found_index = k[5:0];
            end
          end
        end
      end
    endcase
    r.list_len = 7'(shadow_list.size());
    return r;
  endfunction

  // Offers one request, with a random gap first, and predicts its result once taken.
  // Valid stays up after the transaction; the next call replaces its data or drops it, and a drain drops it.
  task automatic send_request(logic [2:0] req, logic [6:0] pos, logic [63:0] value);
    while (!sender_steady && $urandom_range(99) < 25) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, value, pos, req};
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
    expected_results.push_back(apply_list_request(req, pos, value));
  endtask

  // Random value, drawn from the list a third of the time so that finds hit, else a small or a wide one.
  function automatic logic [63:0] pick_value();
    if (shadow_list.size() > 0 && $urandom_range(2) == 0) begin
      return shadow_list[$urandom_range(shadow_list.size() - 1)];
    end
    if ($urandom_range(1) == 0) begin
      return 64'($urandom_range(7));
    end
    return {$urandom, $urandom};
  endfunction

  task automatic send_random_request(int push_weight);
    logic [2:0] req;
    logic [6:0] pos;
    int n;
    n = shadow_list.size();
    req = ($urandom_range(99) < push_weight) ?
          (($urandom_range(2) == 0) ? ile_pkg::REQ_PUSH :
           ($urandom_range(1) ? ile_pkg::REQ_INSERT : ile_pkg::REQ_UNSHIFT)) :
          3'($urandom_range(7));
    // Positions mostly fall inside the list, now and then just past it or anywhere.
    case ($urandom_range(9))
      0: pos = 7'($urandom_range(127));
      1: pos = 7'(n);
      default: pos = 7'($urandom_range(n));
    endcase
    send_request(req, pos, pick_value());
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Extremes on an empty list, every request type, and the edges of the index.
  task automatic test_directed();
    send_request(ile_pkg::REQ_POP, 7'd0, 64'd0);
    send_request(ile_pkg::REQ_SHIFT, 7'd0, 64'd0);
    send_request(ile_pkg::REQ_GET, 7'd0, 64'd0);
    send_request(ile_pkg::REQ_DELETE, 7'd0, 64'd0);
    send_request(ile_pkg::REQ_FIND, 7'd0, 64'd0);
    send_request(ile_pkg::REQ_INSERT, 7'd1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(ile_pkg::REQ_INSERT, 7'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(ile_pkg::REQ_PUSH, 7'd127, 64'h0);
    send_request(ile_pkg::REQ_UNSHIFT, 7'd64, 64'hA5A5_5A5A_F0F0_0F0F);
    send_request(ile_pkg::REQ_INSERT, 7'd3, 64'h5A5A_A5A5_0F0F_F0F0);
    send_request(ile_pkg::REQ_INSERT, 7'd5, 64'h1);
    send_request(ile_pkg::REQ_GET, 7'd3, 64'd0);
    send_request(ile_pkg::REQ_GET, 7'd4, 64'd0);
    send_request(ile_pkg::REQ_GET, 7'd127, 64'd0);
    send_request(ile_pkg::REQ_FIND, 7'd0, 64'h0);
    send_request(ile_pkg::REQ_FIND, 7'd0, 64'h1234);
    send_request(ile_pkg::REQ_DELETE, 7'd4, 64'd0);
    send_request(ile_pkg::REQ_DELETE, 7'd1, 64'd0);
    send_request(ile_pkg::REQ_SHIFT, 7'd0, 64'd0);
    send_request(ile_pkg::REQ_POP, 7'd0, 64'd0);
    send_request(ile_pkg::REQ_GET, 7'd0, 64'd0);
    wait_drained();
  endtask

  // Fills the list to capacity, overflows it, reads the far end and empties it again.
  task automatic test_full_list();
    while (shadow_list.size() < CAPACITY) begin
      send_request(ile_pkg::REQ_PUSH, 7'd0, {$urandom, $urandom});
    end
    send_request(ile_pkg::REQ_PUSH, 7'd0, 64'd1);
    send_request(ile_pkg::REQ_UNSHIFT, 7'd0, 64'd2);
    send_request(ile_pkg::REQ_INSERT, 7'd127, 64'd3);
    send_request(ile_pkg::REQ_GET, 7'd63, 64'd0);
    send_request(ile_pkg::REQ_GET, 7'd64, 64'd0);
    send_request(ile_pkg::REQ_FIND, 7'd0, shadow_list[63]);
    send_request(ile_pkg::REQ_DELETE, 7'd63, 64'd0);
    send_request(ile_pkg::REQ_INSERT, 7'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    while (shadow_list.size() > 0) begin
      send_request($urandom_range(1) ? ile_pkg::REQ_SHIFT : ile_pkg::REQ_POP, 7'd0, 64'd0);
    end
    wait_drained();
  endtask

  // The receiver holds off while requests keep coming, so the engine stalls its input.
  task automatic test_backpressure();
    receiver_holdoff = 300;
    repeat (40) begin
      send_random_request(50);
    end
    wait_drained();
  endtask

  // Random traffic in phases that alternately grow and shrink the list, with one steady stretch.
  task automatic test_random_traffic();
    for (int i = 0; i < 1800; i++) begin
      sender_steady   = (i >= 600 && i < 800);
      receiver_steady = sender_steady;
      send_random_request(((i / 300) % 2 == 0) ? 60 : 15);
    end
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;
    wait_drained();
  endtask

  // Receiver: random stalls, plus a hold-off when one is asked for.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (receiver_holdoff > 0) begin
      receiver_holdoff <= receiver_holdoff - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= receiver_steady || ($urandom_range(99) >= 25);
    end
  end

  // Result checker and idle watchdog.
  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles > IDLE_LIMIT && !done) begin
        $display("indexed_list_engine_test: errors");
        $finish;
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_results.size() == 0) begin
          $error("result transaction with no request outstanding: %h", m_tdata);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            error_count++;
          end
          if (got.read_data !== want.read_data) begin
            $error("read_data: expected %h, actual %h", want.read_data, got.read_data);
            error_count++;
          end
          if (got.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, got.found);
            error_count++;
          end
          if (got.found_index !== want.found_index) begin
            $error("found_index: expected %0d, actual %0d", want.found_index,
                   got.found_index);
            error_count++;
          end
          if (got.list_len !== want.list_len) begin
            $error("list_len: expected %0d, actual %0d", want.list_len,
                   got.list_len);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    rst              = 1'b1;
    s_tvalid         = 1'b0;
    s_tdata          = '0;
    error_count      = 0;
    idle_cycles      = 0;
    sender_steady    = 1'b0;
    receiver_steady  = 1'b0;
    receiver_holdoff = 0;
    done             = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_list();
    test_backpressure();
    test_random_traffic();
    // Let any stray result show up before the verdict.
    repeat (200) @(posedge clk);
    done = 1'b1;
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("indexed_list_engine_test: clean");
    end else begin
      $display("indexed_list_engine_test: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/ile_pkg.sv
hw/rtl/ile_ctrl.sv
hw/rtl/ile_dpath.sv
hw/rtl/indexed_list_engine.sv
tb/sv/indexed_list_engine_test.sv
